// ===== sv/mau_pkg.sv =====
package mau_pkg;

    // Datapath width of operands, modulus and result
    localparam int DATA_WIDTH = 31;
    // Bits of a counter that walks over the DATA_WIDTH bit positions
    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_POW = 3'd3;
    localparam logic [2:0] ACT_INV = 3'd4;
    localparam logic [2:0] ACT_DIV = 3'd5;

    typedef struct packed {
        logic [2:0]            action;
        logic [DATA_WIDTH-1:0] operand_a;
        logic [DATA_WIDTH-1:0] operand_b;
        logic [DATA_WIDTH-1:0] exponent;
    } in_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result;
        logic                  zero_divisor;
    } out_item_t;

    // Status of the serial modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

// ===== sv/mau_mulmod.sv =====
// Bit-serial modular multiplier: one bit of y per cycle, MSB first.
// A start pulse loads x and y; after the last bit of y, done pulses with
// product = x * y mod m. Inputs must be below m, m must stay stable.
module mau_mulmod
    import mau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] x,
    input  logic [DATA_WIDTH-1:0] y,
    input  logic [DATA_WIDTH-1:0] m,
    output logic [DATA_WIDTH-1:0] product,
    output mul_status_t           status
);

    localparam int TW = DATA_WIDTH + 2;

    logic [DATA_WIDTH-1:0] x_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] acc_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  last;
    logic [TW-1:0]         t;
    logic [TW-1:0]         m1;
    logic [TW-1:0]         m2;

    assign last = (cnt_reg == CNT_W'(DATA_WIDTH - 1));

    // Double, add x when the bit is set, and bring back below m
    always_comb
    begin
        m1 = TW'(m);
        m2 = {1'b0, m, 1'b0};
        t  = {1'b0, acc_reg, 1'b0} + (y_reg[DATA_WIDTH-1] ? TW'(x_reg) : '0);
        if (t >= m2)
        begin
            acc_next = DATA_WIDTH'(t - m2);
        end
        else if (t >= m1)
        begin
            acc_next = DATA_WIDTH'(t - m1);
        end
        else
        begin
            acc_next = DATA_WIDTH'(t);
        end
    end

    // Control: busy while bits remain, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[DATA_WIDTH-2:0], 1'b0};
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/modular_arithmetic_unit_core.sv =====
// Channel  Direction  Handshake          Payload
// -------  ---------  -----------------  ------------------------------
// in       input      in_valid/in_stall  in_item  (action, operands, exponent)
// out      output     out_valid/out_stall out_item (result, zero_divisor)
// cfg      input      cfg_valid/cfg_ready cfg_data (modulus)
//
// One item at a time. Operands are first reduced modulo the modulus by
// bit-serial restoring remainder. Each modular multiply runs in the
// bit-serial multiplier; power, inverse and divide run one square and at
// most one multiply per exponent bit, divide then one final multiply, and
// multiply a single one. Add and subtract are done in S_DISPATCH, after
// reduction. Reset loads modulus 5. The output register holds a result
// under out_stall while the next item is accepted and worked on.
module modular_arithmetic_unit_core
    import mau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [DATA_WIDTH-1:0] cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_REDUCE   = 10'b0000000010,
        S_DISPATCH = 10'b0000000100,
        S_SQ       = 10'b0000001000,
        S_SQ_WAIT  = 10'b0000010000,
        S_ML       = 10'b0000100000,
        S_ML_WAIT  = 10'b0001000000,
        S_FM       = 10'b0010000000,
        S_FM_WAIT  = 10'b0100000000,
        S_FINISH   = 10'b1000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [DATA_WIDTH-1:0] mod_reg;
    logic [DATA_WIDTH-1:0] m_reg;
    logic [2:0]            act_reg;
    logic [DATA_WIDTH-1:0] opa_reg, opa_next;
    logic [DATA_WIDTH-1:0] opb_reg, opb_next;
    logic [DATA_WIDTH-1:0] ra_reg, ra_next;
    logic [DATA_WIDTH-1:0] rb_reg, rb_next;
    logic [DATA_WIDTH-1:0] exp_reg, exp_next;
    logic [DATA_WIDTH-1:0] base_reg, base_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic                  flag_reg, flag_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg;
    logic                  out_load;
    logic                  in_accept;
    logic                  last_bit;

    logic [DATA_WIDTH:0]   mw;
    logic [DATA_WIDTH:0]   ra_shift;
    logic [DATA_WIDTH:0]   rb_shift;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH-1:0] add_res;
    logic [DATA_WIDTH-1:0] sub_res;

    logic                  mul_start;
    logic [DATA_WIDTH-1:0] mul_x;
    logic [DATA_WIDTH-1:0] mul_y;
    logic [DATA_WIDTH-1:0] mul_p;
    mul_status_t           mul_st;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign last_bit  = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    // Modulus register; a zero modulus acts as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= DATA_WIDTH'(5);
        end
        else if (cfg_valid && cfg_ready)
        begin
            mod_reg <= cfg_data;
        end
    end

    // Reduction step, add and subtract on the residues
    always_comb
    begin
        mw       = {1'b0, m_reg};
        ra_shift = {ra_reg, opa_reg[DATA_WIDTH-1]};
        rb_shift = {rb_reg, opb_reg[DATA_WIDTH-1]};
        sum      = {1'b0, ra_reg} + {1'b0, rb_reg};
        add_res  = (sum >= mw) ? DATA_WIDTH'(sum - mw) : DATA_WIDTH'(sum);
        if (ra_reg >= rb_reg)
        begin
            sub_res = ra_reg - rb_reg;
        end
        else
        begin
            sub_res = DATA_WIDTH'({1'b0, ra_reg} + mw - {1'b0, rb_reg});
        end
    end

    // Multiplier operand select
    always_comb
    begin
        mul_start = (state_reg == S_SQ) || (state_reg == S_ML) || (state_reg == S_FM);
        case (state_reg)
            S_ML:
            begin
                mul_x = acc_reg;
                mul_y = base_reg;
            end
            S_FM:
            begin
                mul_x = ra_reg;
                mul_y = acc_reg;
            end
            default:
            begin
                mul_x = acc_reg;
                mul_y = acc_reg;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        exp_next   = exp_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        flag_next  = flag_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    opa_next   = in_item.operand_a;
                    opb_next   = in_item.operand_b;
                    exp_next   = in_item.exponent;
                    ra_next    = '0;
                    rb_next    = '0;
                    cnt_next   = '0;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                ra_next  = (ra_shift >= mw) ? DATA_WIDTH'(ra_shift - mw)
                                            : DATA_WIDTH'(ra_shift);
                rb_next  = (rb_shift >= mw) ? DATA_WIDTH'(rb_shift - mw)
                                            : DATA_WIDTH'(rb_shift);
                opa_next = {opa_reg[DATA_WIDTH-2:0], 1'b0};
                opb_next = {opb_reg[DATA_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (last_bit)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_next  = '0;
                flag_next = 1'b0;
                cnt_next  = '0;
                acc_next  = (m_reg == DATA_WIDTH'(1)) ? '0 : DATA_WIDTH'(1);
                base_next = ra_reg;
                case (act_reg)
                    ACT_ADD:
                    begin
                        res_next   = add_res;
                        state_next = S_FINISH;
                    end
                    ACT_SUB:
                    begin
                        res_next   = sub_res;
                        state_next = S_FINISH;
                    end
                    ACT_MUL:
                    begin
                        acc_next   = rb_reg;
                        state_next = S_FM;
                    end
                    ACT_POW:
                    begin
                        state_next = S_SQ;
                    end
                    ACT_INV:
                    begin
                        exp_next = m_reg - DATA_WIDTH'(2);
                        if (ra_reg == '0)
                        begin
                            flag_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SQ;
                        end
                    end
                    ACT_DIV:
                    begin
                        exp_next  = m_reg - DATA_WIDTH'(2);
                        base_next = rb_reg;
                        if (rb_reg == '0)
                        begin
                            flag_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SQ;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SQ:
            begin
                state_next = S_SQ_WAIT;
            end
            S_ML:
            begin
                state_next = S_ML_WAIT;
            end
            S_SQ_WAIT, S_ML_WAIT:
            begin
                if (mul_st.done)
                begin
                    acc_next = mul_p;
                    if ((state_reg == S_SQ_WAIT) && exp_reg[DATA_WIDTH-1])
                    begin
                        state_next = S_ML;
                    end
                    else
                    begin
                        // Advance to the next exponent bit
                        exp_next = {exp_reg[DATA_WIDTH-2:0], 1'b0};
                        cnt_next = cnt_reg + 1'b1;
                        if (!last_bit)
                        begin
                            state_next = S_SQ;
                        end
                        else if (act_reg == ACT_DIV)
                        begin
                            state_next = S_FM;
                        end
                        else
                        begin
                            res_next   = mul_p;
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_FM:
            begin
                state_next = S_FM_WAIT;
            end
            S_FM_WAIT:
            begin
                if (mul_st.done)
                begin
                    res_next   = mul_p;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: fill on finish, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg <= in_item.action;
            m_reg   <= (mod_reg == '0) ? DATA_WIDTH'(1) : mod_reg;
        end
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        exp_reg  <= exp_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        flag_reg <= flag_next;
        if (out_load)
        begin
            out_reg.result       <= res_reg;
            out_reg.zero_divisor <= flag_reg;
        end
    end

    mau_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .m       (m_reg),
        .product (mul_p),
        .status  (mul_st)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== sv/mau_checker.sv =====
module mau_checker
    import mau_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input in_item_t              in_item,
    input logic                  out_valid,
    input logic                  out_stall,
    input out_item_t             out_item,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [DATA_WIDTH-1:0] cfg_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    // A zero divisor always comes with a zero result
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.zero_divisor |-> out_item.result == '0)
        else $error("zero divisor with nonzero result");

    // An accepted item keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after accepting an item");

    // A new result appears only at the end of item work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in work");

endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (.*);
